>>> hdl/cwfe_pkg.sv
// Shared types and widths for the clip window and fade envelope core.
package cwfe_pkg;

    localparam int POS_W  = 32;             // track position and clip placement
    localparam int IDX_W  = 24;             // source index and fade lengths
    localparam int GAIN_W = 16;             // Q4.12 gain and scale
    localparam int PROD_W = IDX_W + GAIN_W; // ramp numerator times gain
    localparam int DIVD_W = PROD_W + 1;     // product plus half divisor
    localparam int Q_W    = GAIN_W;         // quotient never exceeds the gain
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PLACE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOUT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd5;

    // Configuration as seen by the datapath (place, first and last already masked)
    typedef struct packed {
        logic [POS_W-1:0]  place;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last;
        logic [IDX_W-1:0]  fin;
        logic [IDX_W-1:0]  fout;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // Per-item side data that rides along the arithmetic
    typedef struct packed {
        logic             in_window;
        logic [IDX_W-1:0] source_index;
    } t_meta;

    // Ramp fraction num/den picked by the window logic
    typedef struct packed {
        t_meta            meta;
        logic [IDX_W-1:0] num;
        logic [IDX_W-1:0] den;
    } t_frac;

    // Rounded dividend and divisor entering the divider
    typedef struct packed {
        t_meta             meta;
        logic [DIVD_W-1:0] rem;
        logic [IDX_W-1:0]  den;
    } t_divin;

    // Finished item
    typedef struct packed {
        t_meta          meta;
        logic [Q_W-1:0] scale;
    } t_result;

endpackage

>>> hdl/cwfe_front.sv
// Window test and ramp selection, four pipeline stages.
module cwfe_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [cwfe_pkg::POS_W-1:0] i_track,
    input  cwfe_pkg::t_cfg         i_cfg,
    output logic                   o_valid,
    output cwfe_pkg::t_frac        o_data
);
    import cwfe_pkg::*;

    logic [IDX_W-1:0] fin_m1;
    logic [IDX_W-1:0] fout_m1;
    logic             fin_on;
    logic             fout_on;

    // Stage 1: local position and window span
    logic [POS_W:0]   n1_diff;
    logic             r1_v;
    logic             r1_out;
    logic [POS_W-1:0] r1_p;
    logic [IDX_W-1:0] r1_span;

    // Stage 2: window compare, fade-in test, fade-out sum
    logic             n2_in_win;
    logic [IDX_W-1:0] n2_p;
    logic             r2_v;
    logic             r2_in_win;
    logic             r2_fi;
    logic [IDX_W-1:0] r2_p;
    logic [IDX_W:0]   r2_t;
    logic [IDX_W:0]   r2_len;

    // Stage 3: fade-out test and offset into the ramp
    logic [IDX_W+1:0] n3_diff;
    logic             r3_v;
    logic             r3_in_win;
    logic             r3_fi;
    logic             r3_fo;
    logic [IDX_W-1:0] r3_p;
    logic [IDX_W:0]   r3_d;
    logic [IDX_W-1:0] r3_src;

    // Stage 4: fraction select
    logic [IDX_W+1:0] n4_diff;
    logic [IDX_W-1:0] n4_num_fo;
    t_frac            n4_frac;
    logic             r4_v;
    t_frac            r4_frac;

    assign fin_m1  = i_cfg.fin - IDX_W'(1);
    assign fout_m1 = i_cfg.fout - IDX_W'(1);
    assign fin_on  = i_cfg.fin > IDX_W'(1);
    assign fout_on = i_cfg.fout > IDX_W'(1);

    assign n1_diff = {1'b0, i_track} - {1'b0, i_cfg.place};

    assign n2_in_win = !r1_out && (r1_p <= POS_W'(r1_span));
    assign n2_p      = r1_p[IDX_W-1:0];

    assign n3_diff = {1'b0, r2_t} - {1'b0, r2_len};

    // Clip the fade-out offset at the ramp length
    assign n4_diff   = {2'b00, fout_m1} - {1'b0, r3_d};
    assign n4_num_fo = n4_diff[IDX_W+1] ? '0 : n4_diff[IDX_W-1:0];

    // Pick num/den: silence, fade-in, fade-out or unity
    always_comb begin
        n4_frac.meta.in_window    = r3_in_win;
        n4_frac.meta.source_index = r3_in_win ? r3_src : '0;
        if (!r3_in_win) begin
            n4_frac.num = '0;
            n4_frac.den = IDX_W'(1);
        end else if (r3_fi) begin
            n4_frac.num = r3_p;
            n4_frac.den = fin_m1;
        end else if (r3_fo) begin
            n4_frac.num = n4_num_fo;
            n4_frac.den = fout_m1;
        end else begin
            n4_frac.num = IDX_W'(1);
            n4_frac.den = IDX_W'(1);
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_out  <= n1_diff[POS_W] || (i_cfg.last < i_cfg.first);
            r1_p    <= n1_diff[POS_W-1:0];
            r1_span <= i_cfg.last - i_cfg.first;

            r2_in_win <= n2_in_win;
            r2_p      <= n2_p;
            r2_fi     <= fin_on && (n2_p <= fin_m1);
            r2_t      <= {1'b0, n2_p} + {1'b0, i_cfg.fout};
            r2_len    <= {1'b0, r1_span} + (IDX_W+1)'(1);

            r3_in_win <= r2_in_win;
            r3_fi     <= r2_fi;
            r3_fo     <= fout_on && !n3_diff[IDX_W+1];
            r3_p      <= r2_p;
            r3_d      <= n3_diff[IDX_W:0];
            r3_src    <= i_cfg.first + r2_p;

            r4_frac <= n4_frac;
        end
    end

    assign o_valid = r4_v;
    assign o_data  = r4_frac;

endmodule

>>> hdl/cwfe_mul.sv
// Gain multiply and rounding offset, two pipeline stages.
module cwfe_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  cwfe_pkg::t_frac            i_data,
    input  logic [cwfe_pkg::GAIN_W-1:0] i_gain,
    output logic                       o_valid,
    output cwfe_pkg::t_divin           o_data
);
    import cwfe_pkg::*;

    logic              r1_v;
    t_meta             r1_meta;
    logic [PROD_W-1:0] r1_prod;
    logic [IDX_W-1:0]  r1_den;
    logic              r2_v;
    t_divin            r2_data;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    // Multiply, then add half the divisor for round-half-up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_meta <= i_data.meta;
            r1_prod <= PROD_W'(i_data.num) * PROD_W'(i_gain);
            r1_den  <= i_data.den;

            r2_data.meta <= r1_meta;
            r2_data.rem  <= DIVD_W'(r1_prod) + DIVD_W'(r1_den >> 1);
            r2_data.den  <= r1_den;
        end
    end

    assign o_valid = r2_v;
    assign o_data  = r2_data;

endmodule

>>> hdl/cwfe_div.sv
// Restoring divider, one quotient bit per pipeline stage.
module cwfe_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  cwfe_pkg::t_divin    i_data,
    output logic                o_valid,
    output cwfe_pkg::t_result   o_data
);
    import cwfe_pkg::*;

    logic              r_v    [Q_W];
    t_meta             r_meta [Q_W];
    logic [DIVD_W-1:0] r_rem  [Q_W];
    logic [IDX_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_q    [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;

        logic              v_in;
        t_meta             meta_in;
        logic [DIVD_W-1:0] rem_in;
        logic [IDX_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic [DIVD_W-1:0] sub_d;
        logic [DIVD_W:0]   diff;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign meta_in = i_data.meta;
            assign rem_in  = i_data.rem;
            assign den_in  = i_data.den;
            assign q_in    = '0;
        end else begin : g_body
            assign v_in    = r_v[k-1];
            assign meta_in = r_meta[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
        end

        // Trial subtract of the shifted divisor
        assign sub_d = DIVD_W'(den_in) << SH;
        assign diff  = {1'b0, rem_in} - {1'b0, sub_d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        // Keep the difference and set the bit when it does not go negative
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[k] <= meta_in;
                r_den[k]  <= den_in;
                if (!diff[DIVD_W]) begin
                    r_rem[k] <= diff[DIVD_W-1:0];
                    r_q[k]   <= q_in | (Q_W'(1) << SH);
                end else begin
                    r_rem[k] <= rem_in;
                    r_q[k]   <= q_in;
                end
            end
        end
    end

    assign o_valid      = r_v[Q_W-1];
    assign o_data.meta  = r_meta[Q_W-1];
    assign o_data.scale = r_q[Q_W-1];

endmodule

>>> hdl/clip_window_fade_envelope_core.sv
// Top level: configuration registers, envelope pipeline and output skid buffer.
//
//  channel   direction  handshake                    payload
//  cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//  in        in         i_in_valid  / o_in_ready     i_track_frame
//  out       out        o_out_valid / i_out_ready    o_in_window, o_source_index, o_scale
//
// One item per cycle sustained while the skid register is empty. An item crosses
// 23 registers (4 window stages, 2 multiply and round stages, 16 divider stages,
// output register), the last of which drives o_out_valid. The divider, one quotient
// bit per stage, sets the latency.
// Reset is synchronous; it clears valid bits, loads the register reset values and
// holds both ready outputs low.
// A stalled output fills a skid register; the pipeline then holds until it drains.
module clip_window_fade_envelope_core #(
    parameter int INDEX_BITS    = 24,
    parameter int POSITION_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cwfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cwfe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cwfe_pkg::POS_W-1:0]      i_track_frame,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_in_window,
    output logic [cwfe_pkg::IDX_W-1:0]      o_source_index,
    output logic [cwfe_pkg::GAIN_W-1:0]     o_scale
);
    import cwfe_pkg::*;

    localparam int PW_EFF = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
    localparam int IW_EFF = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
    localparam logic [POS_W:0]   POS_ONE  = 1;
    localparam logic [IDX_W:0]   IDX_ONE  = 1;
    localparam logic [POS_W-1:0] POS_MASK = POS_W'((POS_ONE << PW_EFF) - POS_ONE);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((IDX_ONE << IW_EFF) - IDX_ONE);

    logic [POS_W-1:0]  r_place;
    logic [IDX_W-1:0]  r_first;
    logic [IDX_W-1:0]  r_last;
    logic [IDX_W-1:0]  r_fin;
    logic [IDX_W-1:0]  r_fout;
    logic [GAIN_W-1:0] r_gain;
    t_cfg              cfg;

    logic              en;
    logic              front_v;
    t_frac             front_d;
    logic              mul_v;
    t_divin            mul_d;
    logic              div_v;
    t_result           div_d;

    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;
    logic              take;
    logic              push;

    // Configuration writes, masked to register width; refuse them during reset
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_fin   <= '0;
            r_fout  <= '0;
            r_gain  <= GAIN_W'(4096);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PLACE: r_place <= i_cfg_data[POS_W-1:0];
                REG_FIRST: r_first <= i_cfg_data[IDX_W-1:0];
                REG_LAST:  r_last  <= i_cfg_data[IDX_W-1:0];
                REG_FIN:   r_fin   <= i_cfg_data[IDX_W-1:0];
                REG_FOUT:  r_fout  <= i_cfg_data[IDX_W-1:0];
                REG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Trim place, first and last to the configured widths; fade lengths pass unmasked
    assign cfg.place = r_place & POS_MASK;
    assign cfg.first = r_first & IDX_MASK;
    assign cfg.last  = r_last & IDX_MASK;
    assign cfg.fin   = r_fin;
    assign cfg.fout  = r_fout;
    assign cfg.gain  = r_gain;

    // Pipeline moves whenever the skid register is free; take no item during reset
    assign en         = !r_skid_valid;
    assign o_in_ready = en && i_rst_n;

    cwfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_track (i_track_frame & POS_MASK),
        .i_cfg   (cfg),
        .o_valid (front_v),
        .o_data  (front_d)
    );

    cwfe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_data  (front_d),
        .i_gain  (cfg.gain),
        .o_valid (mul_v),
        .o_data  (mul_d)
    );

    cwfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mul_v),
        .i_data  (mul_d),
        .o_valid (div_v),
        .o_data  (div_d)
    );

    // Output register with skid
    assign take = r_out_valid && i_out_ready;
    assign push = en && div_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid <= div_d;
            end else begin
                r_out <= div_d;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_in_window    = r_out.meta.in_window;
    assign o_source_index = r_out.meta.source_index;
    assign o_scale        = r_out.scale;

    // Silent items carry zero index and zero scale
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_window |-> o_scale == '0 && o_source_index == '0)
        else $error("out-of-window item with nonzero payload");

    // Skid holds an item only behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full while output register empty");

    // Skid fills only when the output item was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid loaded without output stall");

endmodule

>>> tb/sv/clip_window_fade_envelope_core_tb.sv
// Testbench for the clip window and fade envelope core, checked item by item.
`timescale 1ns / 100ps

module clip_window_fade_envelope_core_tb;
    import cwfe_pkg::*;

    // Indexes beyond the defined registers; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 90;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_STARVED} t_rx_mode;

    // Holds a shadow copy of the registers and the queue of predicted envelopes
    class envelope_book;
        logic [POS_W-1:0]  reg_place;
        logic [IDX_W-1:0]  reg_first;
        logic [IDX_W-1:0]  reg_last;
        logic [IDX_W-1:0]  reg_fin;
        logic [IDX_W-1:0]  reg_fout;
        logic [GAIN_W-1:0] reg_gain;
        t_result           pending_envelopes[$];
        int                errors;

        function new();
            reg_place = '0;
            reg_first = '0;
            reg_last  = '0;
            reg_fin   = '0;
            reg_fout  = '0;
            reg_gain  = 16'd4096;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PLACE: reg_place = data[POS_W-1:0];
                REG_FIRST: reg_first = data[IDX_W-1:0];
                REG_LAST:  reg_last  = data[IDX_W-1:0];
                REG_FIN:   reg_fin   = data[IDX_W-1:0];
                REG_FOUT:  reg_fout  = data[IDX_W-1:0];
                REG_GAIN:  reg_gain  = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // round(num * gain / den), halves up
        function logic [63:0] rounded_ratio(logic [63:0] num, logic [63:0] den);
            logic [63:0] prod;
            prod = num * 64'(reg_gain);
            return (prod + den / 2) / den;
        endfunction

        function t_result envelope_at(logic [POS_W-1:0] track);
            t_result     r;
            logic [63:0] p, span, len, fin_w, fout_w, m, d, sc;
            r = '0;
            fin_w  = 64'(reg_fin);
            fout_w = 64'(reg_fout);
            if (track < reg_place || reg_last < reg_first)
                return r;
            p    = 64'(track) - 64'(reg_place);
            span = 64'(reg_last) - 64'(reg_first);
            if (p > span)
                return r;
            len = span + 1;
            // Fade-in wins where both ramps cover the frame
            if (fin_w > 1 && p <= fin_w - 1) begin
                sc = rounded_ratio(p, fin_w - 1);
            end else if (fout_w > 1 && p + fout_w >= len) begin
                m = fout_w - 1;
                d = p + fout_w - len;
                if (d > m)
                    d = m;
                sc = rounded_ratio(m - d, m);
            end else begin
                sc = 64'(reg_gain);
            end
            if (sc > 65535)
                sc = 65535;
            r.meta.in_window    = 1'b1;
            r.meta.source_index = reg_first + p[IDX_W-1:0];
            r.scale             = sc[GAIN_W-1:0];
            return r;
        endfunction

        function void note_frame(logic [POS_W-1:0] track);
            pending_envelopes.push_back(envelope_at(track));
        endfunction

        function int pending_count();
            return pending_envelopes.size();
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_envelopes.size() == 0) begin
                report("result arrived with nothing predicted");
                return;
            end
            want = pending_envelopes.pop_front();
            if (got.meta.in_window !== want.meta.in_window)
                report($sformatf("in_window got %0b want %0b",
                                 got.meta.in_window, want.meta.in_window));
            if (got.meta.source_index !== want.meta.source_index)
                report($sformatf("source_index got %h want %h",
                                 got.meta.source_index, want.meta.source_index));
            if (got.scale !== want.scale)
                report($sformatf("scale got %h want %h", got.scale, want.scale));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [POS_W-1:0]      i_track_frame = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_window;
    logic [IDX_W-1:0]      o_source_index;
    logic [GAIN_W-1:0]     o_scale;

    envelope_book sb = new();
    t_rx_mode     rx_mode = RX_FREE;
    int           rx_tick = 0;
    int           idle_cycles = 0;
    int           gap_max = 0;
    int           burst_max = 1;

    // Window shape of the current setting, steers the frame generator
    logic [POS_W-1:0] cur_place = '0;
    int               cur_span = 0;
    int               cur_fin = 0;
    int               cur_fout = 0;

    clip_window_fade_envelope_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_track_frame  (i_track_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_in_window    (o_in_window),
        .o_source_index (o_source_index),
        .o_scale        (o_scale)
    );

    always #10 i_clk = ~i_clk;

    // Check accepted results and drive the receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_in_window, o_source_index, o_scale});
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_FREE:    i_out_ready <= 1'b1;
            RX_RANDOM:  i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: i_out_ready <= ((rx_tick % 11) > 3);
            default:    i_out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Count cycles in which no channel moves an item
    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Write all registers, optionally with garbage above each register's width
    task write_setting(input logic [POS_W-1:0] place, input logic [IDX_W-1:0] first,
                       input logic [IDX_W-1:0] last, input logic [IDX_W-1:0] fin,
                       input logic [IDX_W-1:0] fout, input logic [GAIN_W-1:0] gain,
                       input bit junk);
        logic [31:0] hi;
        hi = junk ? $urandom : 32'd0;
        cfg_write(REG_PLACE, place);
        cfg_write(REG_FIRST, {hi[31:24], first});
        cfg_write(REG_LAST, {hi[23:16], last});
        cfg_write(REG_FIN, {hi[15:8], fin});
        cfg_write(REG_FOUT, {hi[7:0], fout});
        cfg_write(REG_GAIN, {hi[31:16], gain});
        cfg_write(REG_SPARE6, $urandom);
        cfg_write(REG_SPARE7, $urandom);
        i_cfg_valid <= 1'b0;
        cur_place = place;
        cur_span  = (last < first) ? 40 : int'(last - first);
        cur_fin   = int'(fin);
        cur_fout  = int'(fout);
    endtask

    task send_frame(input logic [POS_W-1:0] track);
        i_in_valid    <= 1'b1;
        i_track_frame <= track;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_frame(track);
    endtask

    task idle_in(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold the sender until every predicted envelope has been checked
    task wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    task random_setting();
        logic [POS_W-1:0]  place;
        logic [IDX_W-1:0]  first, fin, fout;
        logic [GAIN_W-1:0] gain;
        int                span, last_w, lim;
        place = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
        first = IDX_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100));
        case ($urandom_range(0, 7))
            0:       span = $urandom_range(0, 3);
            1, 2, 3: span = $urandom_range(4, 64);
            4, 5:    span = $urandom_range(65, 3000);
            6:       span = $urandom_range(0, 24'hFFFFFF);
            default: span = -1;
        endcase
        if (span < 0) begin
            // Inverted window: last below first
            if (first == 0)
                first = IDX_W'($urandom_range(1, 500));
            last_w = $urandom_range(0, int'(first) - 1);
            lim    = 40;
        end else begin
            last_w = int'(first) + span;
            if (last_w > 24'hFFFFFF)
                last_w = 24'hFFFFFF;
            lim = last_w - int'(first);
        end
        case ($urandom_range(0, 5))
            0:       fin = '0;
            1:       fin = IDX_W'(1);
            2, 3:    fin = IDX_W'($urandom_range(2, lim + 8));
            4:       fin = IDX_W'($urandom_range(2, 40));
            default: fin = IDX_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       fout = '0;
            1:       fout = IDX_W'(1);
            2, 3:    fout = IDX_W'($urandom_range(2, lim + 8));
            4:       fout = IDX_W'($urandom_range(2, 40));
            default: fout = IDX_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       gain = 16'd4096;
            1:       gain = 16'd0;
            2:       gain = 16'hFFFF;
            default: gain = GAIN_W'($urandom);
        endcase
        write_setting(place, first, last_w[IDX_W-1:0], fin, fout, gain,
                      $urandom_range(0, 1) == 1);
    endtask

    // Mostly frames around the window edges and fade ramps, some anywhere
    function logic [POS_W-1:0] next_track();
        int off, fin_reach, fout_reach;
        fin_reach  = (cur_fin > 64) ? 64 : cur_fin;
        fout_reach = (cur_fout > 64) ? 64 : cur_fout;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: off = $urandom_range(0, cur_span + 6) - 3;
            6, 7:    off = cur_span + 3 - $urandom_range(0, 6 + fout_reach);
            default: off = $urandom_range(0, fin_reach + 3) - 3;
        endcase
        return cur_place + off;
    endfunction

    task random_phase(input int n_items, input bit pause_midway);
        int burst, gap, k;
        burst = 0;
        for (k = 0; k < n_items; k++) begin
            if (pause_midway && k == n_items / 2)
                wait_drain();
            if (burst == 0) begin
                burst = $urandom_range(1, burst_max);
                gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                if (gap > 0)
                    idle_in(gap);
            end
            send_frame(next_track());
            burst--;
        end
    endtask

    initial begin
        int ph;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: one-frame window at position zero, unity gain
        send_frame(32'd0);
        send_frame(32'd1);
        send_frame(32'hFFFF_FFFF);
        wait_drain();

        // Before the clip, fade-in ramp, flat part, fade-out down to zero, past the end
        write_setting(32'd100, 24'd10, 24'd40, 24'd5, 24'd8, 16'd4096, 1'b0);
        send_frame(32'd99);
        send_frame(32'd100);
        send_frame(32'd102);
        send_frame(32'd104);
        send_frame(32'd105);
        send_frame(32'd122);
        send_frame(32'd123);
        send_frame(32'd130);
        send_frame(32'd131);
        wait_drain();

        // Fades longer than the clip, overlapping; wide register values masked
        rx_mode = RX_RANDOM;
        write_setting(32'd0, 24'd0, 24'd9, 24'd20, 24'd20, 16'hFFFF, 1'b1);
        send_frame(32'd0);
        send_frame(32'd5);
        send_frame(32'd9);
        send_frame(32'd10);
        wait_drain();

        // Inverted window, then a window at the top of both ranges with zero gain
        write_setting(32'hFFFF_FFFF, 24'd50, 24'd49, 24'd1, 24'd1, 16'd0, 1'b0);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd0);
        wait_drain();
        write_setting(32'hFFFF_FFFF, 24'hFFFFF0, 24'hFFFFFF, 24'd1, 24'd1, 16'd0, 1'b1);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFE);
        wait_drain();

        // Full-length window with a fade-out spanning all of it
        rx_mode = RX_PATTERN;
        write_setting(32'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 16'd12345, 1'b0);
        send_frame(32'd0);
        send_frame(32'h00FF_FFFF);
        send_frame(32'h0100_0000);
        send_frame(32'h0080_0000);
        wait_drain();

        // Random settings, each with its own traffic shape
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            rx_mode   = t_rx_mode'(ph % 4);
            gap_max   = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
            burst_max = $urandom_range(1, 20);
            random_setting();
            random_phase(PHASE_ITEMS, ph == 5);
            wait_drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.pending_count() != 0)
            sb.report($sformatf("%0d predicted results never arrived", sb.pending_count()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
